// ===== sv/rsb_pkg.sv =====
// Package for the restart supervisor with exponential backoff.
// Holds state, command and cause codes, register indexes and defaults.
// No dependencies.
package rsb_pkg;

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_STARTING = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_STOPPING = 3'd3,
    ST_BACKOFF  = 3'd4,
    ST_FAILED   = 3'd5
  } mod_state_e;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_READY   = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_EXITED  = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_FAIL    = 3'd5,
    CMD_SIGSENT = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CAUSE_REQUESTED = 2'd0,
    CAUSE_CLEAN     = 2'd1,
    CAUSE_FAILED    = 2'd2,
    CAUSE_TIMEOUT   = 2'd3
  } cause_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    SQ_IDLE  = 3'd0,
    SQ_EXEC  = 3'd1,
    SQ_SCAN  = 3'd2,
    SQ_PUSH  = 3'd3,
    SQ_DONE  = 3'd4,
    SQ_OUT   = 3'd5
  } seq_e;

  localparam int unsigned REG_POLICY   = 0;
  localparam int unsigned REG_HS_TMO   = 1;
  localparam int unsigned REG_INIT_BO  = 2;
  localparam int unsigned REG_MAX_BO   = 3;
  localparam int unsigned REG_HEALTHY  = 4;
  localparam int unsigned REG_GRACEFUL = 5;
  localparam int unsigned REG_TERM     = 6;

  localparam int unsigned FAIL_LIMIT_DEF     = 10;
  localparam int unsigned FAIL_WINDOW_MS_DEF = 300000;
  localparam int unsigned RING_DEPTH_DEF     = 16;

  localparam logic [1:0]  POLICY_RST   = 2'd1;
  localparam logic [31:0] HS_TMO_RST   = 32'd5000;
  localparam logic [31:0] INIT_BO_RST  = 32'd1000;
  localparam logic [31:0] MAX_BO_RST   = 32'd60000;
  localparam logic [31:0] HEALTHY_RST  = 32'd60000;
  localparam logic [31:0] GRACEFUL_RST = 32'd10000;
  localparam logic [31:0] TERM_RST     = 32'd5000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [1:0]  stop_cause;
    logic        signal_kind;
  } evt_t;

  typedef struct packed {
    logic        accepted;
    logic        changed;
    logic [2:0]  prev_state;
    logic [2:0]  new_state;
    logic [1:0]  transition_cause;
    logic        signal_due;
    logic        due_kind;
    logic        deadline_valid;
    logic [31:0] deadline_ms;
  } res_t;

endpackage

// ===== sv/rsb_evt_if.sv =====
// Valid/ready channel interfaces for event items and result items.
// Depends on rsb_pkg.
interface rsb_evt_if;
  logic          valid;
  logic          ready;
  rsb_pkg::evt_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rsb_res_if;
  logic          valid;
  logic          ready;
  rsb_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/restart_supervisor_backoff_top.sv =====
// Top level of the restart supervisor with exponential backoff.
// Depends on rsb_pkg and the channel interfaces in rsb_evt_if.sv.
//
// One event item at a time: the block takes an item only while its sequencer
// is idle. Most items pass from acceptance through execute, resolve and output
// to the output register. A failed exit that is recorded in the failure ring
// also passes through the ring scan and the push. The scan reads one stored
// failure time a cycle through a single compare and drops expired entries until
// the ring is empty or it meets an entry that has not expired. The block is
// ready again in the cycle after the result register is loaded; a result
// waiting at the output holds the block only once the next item reaches its
// output step. Deadlines are kept at 33 bits.
module restart_supervisor_backoff_top #(
  parameter int unsigned FAIL_LIMIT     = rsb_pkg::FAIL_LIMIT_DEF,
  parameter int unsigned FAIL_WINDOW_MS = rsb_pkg::FAIL_WINDOW_MS_DEF,
  parameter int unsigned RING_DEPTH     = rsb_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsb_evt_if.sink     evt_i,
  rsb_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [32:0] WIN = 33'(FAIL_WINDOW_MS);

  // Configuration registers.
  logic [1:0]  policy_q;
  logic [31:0] hs_tmo_q, init_bo_q, max_bo_q, healthy_q, graceful_q, term_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= rsb_pkg::POLICY_RST;
      hs_tmo_q   <= rsb_pkg::HS_TMO_RST;
      init_bo_q  <= rsb_pkg::INIT_BO_RST;
      max_bo_q   <= rsb_pkg::MAX_BO_RST;
      healthy_q  <= rsb_pkg::HEALTHY_RST;
      graceful_q <= rsb_pkg::GRACEFUL_RST;
      term_q     <= rsb_pkg::TERM_RST;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      case (32'(cfg_idx))
        rsb_pkg::REG_POLICY:   policy_q   <= pwdata[1:0];
        rsb_pkg::REG_HS_TMO:   hs_tmo_q   <= pwdata;
        rsb_pkg::REG_INIT_BO:  init_bo_q  <= pwdata;
        rsb_pkg::REG_MAX_BO:   max_bo_q   <= pwdata;
        rsb_pkg::REG_HEALTHY:  healthy_q  <= pwdata;
        rsb_pkg::REG_GRACEFUL: graceful_q <= pwdata;
        rsb_pkg::REG_TERM:     term_q     <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (32'(cfg_idx))
      rsb_pkg::REG_POLICY:   prdata = {30'd0, policy_q};
      rsb_pkg::REG_HS_TMO:   prdata = hs_tmo_q;
      rsb_pkg::REG_INIT_BO:  prdata = init_bo_q;
      rsb_pkg::REG_MAX_BO:   prdata = max_bo_q;
      rsb_pkg::REG_HEALTHY:  prdata = healthy_q;
      rsb_pkg::REG_GRACEFUL: prdata = graceful_q;
      rsb_pkg::REG_TERM:     prdata = term_q;
      default:               prdata = 32'd0;
    endcase
  end

  // Supervisor state.
  rsb_pkg::mod_state_e mst_q;
  logic [31:0] bo_q;
  logic        rt_v_q, hs_v_q, sg_v_q, rs_v_q, pend_v_q, pend_k_q, rsn_v_q;
  logic [32:0] rt_q, hs_q, sg_q, rs_q;
  logic [1:0]  rsn_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] ring_mem [RING_DEPTH];
  logic [31:0] ring_rd_q;

  // Sequencer and item registers.
  rsb_pkg::seq_e sq_q, sq_d;
  rsb_pkg::evt_t ev_q;
  rsb_pkg::res_t res_q;
  logic          res_v_q;
  logic          acc_q, chg_q;
  logic [1:0]    tc_q;
  logic [2:0]    prev_q;
  logic          eff_f_q;
  logic [1:0]    eff_q;
  logic [32:0]   cutoff_q;

  logic evt_take, res_free;
  assign res_free = !res_v_q || res_o.ready;
  assign evt_i.ready = (sq_q == rsb_pkg::SQ_IDLE);
  assign evt_take = evt_i.valid && evt_i.ready;
  assign res_o.valid = res_v_q;
  assign res_o.payload = res_q;

  // Shared compare unit: a >= b on 33 bits.
  logic [32:0] cmp_a, cmp_b;
  logic        cmp_ge;
  assign cmp_ge = cmp_a >= cmp_b;

  logic [32:0] now33;
  assign now33 = {1'b0, ev_q.now_ms};

  logic scan_old;
  assign scan_old = (cnt_q != '0) && ({1'b0, ring_rd_q} < cutoff_q);

  always_comb begin
    cmp_a = now33;
    cmp_b = rs_q;
    case (sq_q)
      rsb_pkg::SQ_EXEC: begin
        case (ev_q.cmd)
          rsb_pkg::CMD_TICK:
            if (mst_q == rsb_pkg::ST_STARTING) cmp_b = hs_q;
            else if (mst_q == rsb_pkg::ST_BACKOFF) cmp_b = rt_q;
            else cmp_b = rs_q;
          rsb_pkg::CMD_SIGSENT: cmp_b = sg_q;
          default: cmp_b = rs_q;
        endcase
      end
      rsb_pkg::SQ_DONE: cmp_b = sg_q;
      default: cmp_b = rs_q;
    endcase
  end

  // Healthy running check: runtime compared to the healthy threshold.
  logic [32:0] run_len;
  logic        healthy;
  assign run_len = now33 - rs_q;
  assign healthy = (mst_q == rsb_pkg::ST_RUNNING) && rs_v_q && (now33 >= rs_q)
                   && (run_len >= {1'b0, healthy_q});

  // A module process exists only in these states.
  logic live;
  assign live = (mst_q == rsb_pkg::ST_STARTING) || (mst_q == rsb_pkg::ST_RUNNING)
             || (mst_q == rsb_pkg::ST_STOPPING);

  // Next sequencer state.
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      rsb_pkg::SQ_IDLE: if (evt_take) sq_d = rsb_pkg::SQ_EXEC;
      rsb_pkg::SQ_EXEC:
        if (ev_q.cmd == rsb_pkg::CMD_EXITED && live && eff_f_q) sq_d = rsb_pkg::SQ_SCAN;
        else sq_d = rsb_pkg::SQ_DONE;
      rsb_pkg::SQ_SCAN: if (!scan_old) sq_d = rsb_pkg::SQ_PUSH;
      rsb_pkg::SQ_PUSH: sq_d = rsb_pkg::SQ_DONE;
      rsb_pkg::SQ_DONE: sq_d = rsb_pkg::SQ_OUT;
      rsb_pkg::SQ_OUT:  if (res_free) sq_d = rsb_pkg::SQ_IDLE;
      default: sq_d = rsb_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_q <= rsb_pkg::SQ_IDLE;
    else sq_q <= sq_d;
  end

  // Effective exit cause computed at acceptance.
  logic [1:0] eff_in;
  always_comb begin
    eff_in = evt_i.payload.stop_cause;
    if (mst_q == rsb_pkg::ST_STOPPING && rsn_v_q) eff_in = rsn_q;
    else if (mst_q == rsb_pkg::ST_STARTING &&
             evt_i.payload.stop_cause == rsb_pkg::CAUSE_CLEAN)
      eff_in = rsb_pkg::CAUSE_FAILED;
  end

  logic want_rs;
  always_comb begin
    if (eff_q == rsb_pkg::CAUSE_REQUESTED) want_rs = 1'b0;
    else if (policy_q == 2'd0) want_rs = 1'b1;
    else if (policy_q == 2'd1) want_rs = eff_f_q;
    else want_rs = 1'b0;
  end

  logic [CW-1:0] cnt_push;
  assign cnt_push = (cnt_q >= CW'(RING_DEPTH)) ? cnt_q : cnt_q + CW'(1);

  // Ring index sum; both operands stay below the depth, so one subtract wraps it.
  function automatic logic [IW-1:0] idx_add(logic [IW-1:0] a, logic [CW-1:0] b);
    logic [IW+CW:0] s;
    s = (IW+CW+1)'(a) + (IW+CW+1)'(b);
    if (s >= (IW+CW+1)'(RING_DEPTH)) s = s - (IW+CW+1)'(RING_DEPTH);
    return s[IW-1:0];
  endfunction

  // Ring memory: one write and one registered read a cycle.
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic          wr_en;
  assign rd_idx = (sq_q == rsb_pkg::SQ_SCAN && scan_old) ? idx_add(head_q, CW'(1))
                                                         : head_q;
  assign wr_en  = (sq_q == rsb_pkg::SQ_PUSH);
  assign wr_idx = (cnt_q >= CW'(RING_DEPTH)) ? head_q : idx_add(head_q, cnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) ring_mem[wr_idx] <= ev_q.now_ms;
    ring_rd_q <= ring_mem[rd_idx];
  end

  // Result terms, from the state after the item.
  logic        due_w, dv_w;
  logic [32:0] dl_w;
  assign due_w = (mst_q == rsb_pkg::ST_STOPPING) && pend_v_q && sg_v_q &&
                 (now33 >= sg_q);
  always_comb begin
    dv_w = 1'b0;
    dl_w = 33'd0;
    if (hs_v_q) begin
      dv_w = 1'b1; dl_w = hs_q;
    end
    if (rt_v_q && (!dv_w || rt_q < dl_w)) begin
      dv_w = 1'b1; dl_w = rt_q;
    end
    if (sg_v_q && (!dv_w || sg_q < dl_w)) begin
      dv_w = 1'b1; dl_w = sg_q;
    end
  end

  // Item processing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mst_q <= rsb_pkg::ST_STOPPED;
      bo_q <= rsb_pkg::INIT_BO_RST;
      rt_v_q <= 1'b0; hs_v_q <= 1'b0; sg_v_q <= 1'b0; rs_v_q <= 1'b0;
      pend_v_q <= 1'b0; pend_k_q <= 1'b0; rsn_v_q <= 1'b0; rsn_q <= '0;
      head_q <= '0; cnt_q <= '0;
      res_v_q <= 1'b0;
      acc_q <= 1'b0; chg_q <= 1'b0; tc_q <= '0; prev_q <= '0;
      eff_f_q <= 1'b0; eff_q <= '0;
    end else begin
      if (sq_q == rsb_pkg::SQ_OUT && res_free) res_v_q <= 1'b1;
      else if (res_v_q && res_o.ready) res_v_q <= 1'b0;
      case (sq_q)
        rsb_pkg::SQ_IDLE: if (evt_take) begin
          ev_q <= evt_i.payload;
          eff_q <= eff_in;
          eff_f_q <= eff_in[1];
          cutoff_q <= ({1'b0, evt_i.payload.now_ms} >= WIN) ?
                      {1'b0, evt_i.payload.now_ms} - WIN : 33'd0;
          prev_q <= mst_q;
          acc_q <= 1'b0; chg_q <= 1'b0; tc_q <= '0;
        end
        rsb_pkg::SQ_EXEC: begin
          case (ev_q.cmd)
            rsb_pkg::CMD_START:
              if (mst_q == rsb_pkg::ST_STOPPED || mst_q == rsb_pkg::ST_FAILED) begin
                if (mst_q == rsb_pkg::ST_FAILED) begin
                  head_q <= '0; cnt_q <= '0;
                end
                bo_q <= init_bo_q;
                rt_v_q <= 1'b0; rsn_v_q <= 1'b0; pend_v_q <= 1'b0; sg_v_q <= 1'b0;
                hs_v_q <= 1'b1; hs_q <= now33 + {1'b0, hs_tmo_q};
                acc_q <= 1'b1; chg_q <= 1'b1; mst_q <= rsb_pkg::ST_STARTING;
              end
            rsb_pkg::CMD_READY:
              if (mst_q == rsb_pkg::ST_STARTING) begin
                hs_v_q <= 1'b0; rs_v_q <= 1'b1; rs_q <= now33;
                acc_q <= 1'b1; chg_q <= 1'b1; mst_q <= rsb_pkg::ST_RUNNING;
              end
            rsb_pkg::CMD_TICK: begin
              acc_q <= 1'b1;
              if (mst_q == rsb_pkg::ST_STARTING && hs_v_q && cmp_ge) begin
                hs_v_q <= 1'b0; chg_q <= 1'b1; tc_q <= rsb_pkg::CAUSE_TIMEOUT;
                mst_q <= rsb_pkg::ST_STOPPING;
                rsn_v_q <= 1'b1; rsn_q <= rsb_pkg::CAUSE_TIMEOUT;
                pend_v_q <= 1'b1; pend_k_q <= 1'b0; sg_v_q <= 1'b1; sg_q <= now33;
              end else if (mst_q == rsb_pkg::ST_BACKOFF && rt_v_q && cmp_ge) begin
                rt_v_q <= 1'b0; hs_v_q <= 1'b1; hs_q <= now33 + {1'b0, hs_tmo_q};
                chg_q <= 1'b1; mst_q <= rsb_pkg::ST_STARTING;
              end else if (healthy) begin
                bo_q <= init_bo_q;
              end
            end
            rsb_pkg::CMD_EXITED:
              if (live) begin
                if (healthy) bo_q <= init_bo_q;
                hs_v_q <= 1'b0; rs_v_q <= 1'b0; rsn_v_q <= 1'b0;
                pend_v_q <= 1'b0; sg_v_q <= 1'b0;
                acc_q <= 1'b1; chg_q <= 1'b1; tc_q <= eff_q;
              end else begin
                eff_f_q <= 1'b0;
                eff_q <= rsb_pkg::CAUSE_REQUESTED;
              end
            rsb_pkg::CMD_STOP:
              if (mst_q == rsb_pkg::ST_STARTING || mst_q == rsb_pkg::ST_RUNNING) begin
                acc_q <= 1'b1; chg_q <= 1'b1; mst_q <= rsb_pkg::ST_STOPPING;
                rsn_v_q <= 1'b1; rsn_q <= rsb_pkg::CAUSE_REQUESTED;
                pend_v_q <= 1'b1; pend_k_q <= 1'b0; sg_v_q <= 1'b1;
                sg_q <= now33 + {1'b0, graceful_q};
              end else if (mst_q == rsb_pkg::ST_BACKOFF || mst_q == rsb_pkg::ST_FAILED)
              begin
                rt_v_q <= 1'b0; head_q <= '0; cnt_q <= '0; bo_q <= init_bo_q;
                acc_q <= 1'b1; chg_q <= 1'b1; mst_q <= rsb_pkg::ST_STOPPED;
              end
            rsb_pkg::CMD_FAIL:
              if ((mst_q == rsb_pkg::ST_STARTING || mst_q == rsb_pkg::ST_RUNNING)
                  && ev_q.stop_cause[1]) begin
                acc_q <= 1'b1; chg_q <= 1'b1; tc_q <= ev_q.stop_cause;
                mst_q <= rsb_pkg::ST_STOPPING;
                rsn_v_q <= 1'b1; rsn_q <= ev_q.stop_cause;
                pend_v_q <= 1'b1; pend_k_q <= 1'b0; sg_v_q <= 1'b1; sg_q <= now33;
              end
            rsb_pkg::CMD_SIGSENT:
              if (mst_q == rsb_pkg::ST_STOPPING && pend_v_q &&
                  pend_k_q == ev_q.signal_kind && sg_v_q && cmp_ge) begin
                acc_q <= 1'b1;
                if (!ev_q.signal_kind) begin
                  pend_k_q <= 1'b1; sg_q <= now33 + {1'b0, term_q};
                end else begin
                  pend_v_q <= 1'b0; sg_v_q <= 1'b0;
                end
              end
            default: begin
              head_q <= '0; cnt_q <= '0; bo_q <= init_bo_q; acc_q <= 1'b1;
            end
          endcase
        end
        rsb_pkg::SQ_SCAN: if (scan_old) begin
          head_q <= idx_add(head_q, CW'(1));
          cnt_q <= cnt_q - CW'(1);
        end
        rsb_pkg::SQ_PUSH: begin
          if (cnt_q >= CW'(RING_DEPTH)) head_q <= idx_add(head_q, CW'(1));
          cnt_q <= cnt_push;
        end
        rsb_pkg::SQ_DONE: begin
          // Exit resolution, once any new failure is in the ring.
          if (ev_q.cmd == rsb_pkg::CMD_EXITED && chg_q) begin
            if (eff_f_q && 32'(cnt_q) >= FAIL_LIMIT) begin
              mst_q <= rsb_pkg::ST_FAILED;
            end else if (!want_rs) begin
              mst_q <= rsb_pkg::ST_STOPPED;
            end else begin
              rt_v_q <= 1'b1;
              rt_q <= now33 + {1'b0, eff_f_q ? bo_q : init_bo_q};
              if (eff_f_q) begin
                if (bo_q >= (max_bo_q >> 1)) bo_q <= max_bo_q;
                else if ({bo_q, 1'b0} < {1'b0, max_bo_q}) bo_q <= {bo_q[30:0], 1'b0};
                else bo_q <= max_bo_q;
              end else begin
                bo_q <= init_bo_q;
              end
              mst_q <= rsb_pkg::ST_BACKOFF;
            end
          end
        end
        rsb_pkg::SQ_OUT: if (res_free) begin
          res_q.accepted <= acc_q;
          res_q.changed <= chg_q;
          res_q.prev_state <= prev_q;
          res_q.new_state <= mst_q;
          res_q.transition_cause <= chg_q ? tc_q : 2'd0;
          res_q.signal_due <= due_w;
          res_q.due_kind <= due_w & pend_k_q;
          res_q.deadline_valid <= dv_w;
          res_q.deadline_ms <= dv_w ? (dl_w[32] ? 32'hFFFF_FFFF : dl_w[31:0]) : 32'd0;
        end
        default: ;
      endcase
    end
  end

  // Checks on the sequencer, the failure ring and the result output.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= RING_DEPTH) else $error("ring count exceeds depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_take |=> sq_q == rsb_pkg::SQ_EXEC) else $error("item not started");
  a_push_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q == rsb_pkg::SQ_PUSH |=> sq_q == rsb_pkg::SQ_DONE) else $error("push order");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !res_o.ready |=> res_v_q && $stable(res_q)) else $error("result lost");

endmodule
